// ===== design/daf_pkg.sv =====
// Shared types and constants for the distance alpha fade pipeline.
package daf_pkg;

  localparam int IDX_W     = 16;
  localparam int COORD_W   = 32;
  localparam int ALPHA_W   = 16;
  localparam int SUM_W     = 2 * COORD_W;
  localparam int REM_W     = COORD_W + 4;
  localparam int PROD_W    = COORD_W + ALPHA_W;
  localparam int SQRT_CELLS = COORD_W;
  localparam int DIV_CELLS  = ALPHA_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_START  = 2'd0,
    REG_FADE_END    = 2'd1,
    REG_START_ALPHA = 2'd2,
    REG_END_ALPHA   = 2'd3
  } cfg_reg_t;

  // Control that travels with each transaction down the chain.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             below_start;
    logic             beyond_end;
  } side_t;

endpackage

// ===== design/daf_sqrt_cell.sv =====
// One restoring square-root cell: resolves one root bit from two radicand bits.
module daf_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  daf_pkg::side_t               side_in,
  input  logic [daf_pkg::SUM_W-1:0]    rad_in,
  input  logic [daf_pkg::REM_W-1:0]    rem_in,
  input  logic [daf_pkg::COORD_W-1:0]  root_in,
  output daf_pkg::side_t               side_out,
  output logic [daf_pkg::SUM_W-1:0]    rad_out,
  output logic [daf_pkg::REM_W-1:0]    rem_out,
  output logic [daf_pkg::COORD_W-1:0]  root_out
);
  import daf_pkg::*;

  logic [REM_W-1:0] rem_try;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_try = {rem_in[REM_W-3:0], rad_in[SUM_W-1:SUM_W-2]};
    trial   = {2'b00, root_in, 2'b01};
    fits    = (rem_try >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.idx         <= side_in.idx;
    side_out.below_start <= side_in.below_start;
    side_out.beyond_end  <= side_in.beyond_end;
    rad_out  <= {rad_in[SUM_W-3:0], 2'b00};
    rem_out  <= fits ? (rem_try - trial) : rem_try;
    root_out <= {root_in[COORD_W-2:0], fits};
  end

endmodule

// ===== design/daf_div_cell.sv =====
// One restoring division cell: resolves one quotient bit per cycle.
module daf_div_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [daf_pkg::COORD_W-1:0]  den,
  input  daf_pkg::side_t               side_in,
  input  logic [daf_pkg::COORD_W-1:0]  rem_in,
  input  logic [daf_pkg::ALPHA_W-1:0]  low_in,
  input  logic [daf_pkg::ALPHA_W-1:0]  quo_in,
  output daf_pkg::side_t               side_out,
  output logic [daf_pkg::COORD_W-1:0]  rem_out,
  output logic [daf_pkg::ALPHA_W-1:0]  low_out,
  output logic [daf_pkg::ALPHA_W-1:0]  quo_out
);
  import daf_pkg::*;

  logic [COORD_W:0] rem_try;
  logic [COORD_W:0] diff;
  logic             fits;

  always_comb begin
    rem_try = {rem_in, low_in[ALPHA_W-1]};
    diff    = rem_try - {1'b0, den};
    fits    = (rem_try >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.idx         <= side_in.idx;
    side_out.below_start <= side_in.below_start;
    side_out.beyond_end  <= side_in.beyond_end;
    rem_out <= fits ? diff[COORD_W-1:0] : rem_try[COORD_W-1:0];
    low_out <= {low_in[ALPHA_W-2:0], 1'b0};
    quo_out <= {quo_in[ALPHA_W-2:0], fits};
  end

endmodule

// ===== design/distance_alpha_fade_unit.sv =====
// Top level: distance-driven alpha fade, squares, compare, root and divide chains.
// Throughput: one transaction per cycle; busy is high only during reset.
// Depth is set by the 32-cell square-root chain and the 16-cell divider chain.
// Reset (synchronous, rst high) empties the pipeline and restores register defaults.
// The receiver cannot stall: each result shows for one cycle with done high.
module distance_alpha_fade_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [daf_pkg::IDX_W-1:0]         particle_index,
  input  logic signed [daf_pkg::COORD_W-1:0] disp_x,
  input  logic signed [daf_pkg::COORD_W-1:0] disp_y,
  input  logic signed [daf_pkg::COORD_W-1:0] disp_z,
  input  logic                              cfg_we,
  input  logic [daf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [daf_pkg::COORD_W-1:0]       cfg_data,
  output logic                              done,
  output logic [daf_pkg::IDX_W-1:0]         out_index,
  output logic [daf_pkg::ALPHA_W-1:0]       alpha
);
  import daf_pkg::*;

  logic [COORD_W-1:0] fade_start;
  logic [COORD_W-1:0] fade_end;
  logic [ALPHA_W-1:0] start_alpha;
  logic [ALPHA_W-1:0] end_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start  <= '0;
      fade_end    <= '0;
      start_alpha <= '1;
      end_alpha   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FADE_START:  fade_start  <= cfg_data;
        REG_FADE_END:    fade_end    <= cfg_data;
        REG_START_ALPHA: start_alpha <= cfg_data[ALPHA_W-1:0];
        REG_END_ALPHA:   end_alpha   <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  logic               accept;
  logic [COORD_W-1:0] den;
  logic               fade_up;
  logic [ALPHA_W-1:0] alpha_span;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    den        = fade_end - fade_start;
    fade_up    = (end_alpha >= start_alpha);
    alpha_span = fade_up ? (end_alpha - start_alpha) : (start_alpha - end_alpha);
  end

  // Stage 1: magnitudes; 0x80000000 negates to itself, which is the right magnitude.
  side_t              s1_side;
  logic [COORD_W-1:0] mag_x, mag_y, mag_z;
  logic [SUM_W-1:0]   start_sq, end_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.valid <= 1'b0;
    end else begin
      s1_side.valid <= accept;
    end
    s1_side.idx         <= particle_index;
    s1_side.below_start <= 1'b0;
    s1_side.beyond_end  <= 1'b0;
    mag_x    <= disp_x[COORD_W-1] ? (-disp_x) : disp_x;
    mag_y    <= disp_y[COORD_W-1] ? (-disp_y) : disp_y;
    mag_z    <= disp_z[COORD_W-1] ? (-disp_z) : disp_z;
    start_sq <= SUM_W'(fade_start) * SUM_W'(fade_start);
    end_sq   <= SUM_W'(fade_end) * SUM_W'(fade_end);
  end

  // Stage 2: squares.
  side_t            s2_side;
  logic [SUM_W-1:0] sq_x, sq_y, sq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else begin
      s2_side.valid <= s1_side.valid;
    end
    s2_side.idx         <= s1_side.idx;
    s2_side.below_start <= 1'b0;
    s2_side.beyond_end  <= 1'b0;
    sq_x <= SUM_W'(mag_x) * SUM_W'(mag_x);
    sq_y <= SUM_W'(mag_y) * SUM_W'(mag_y);
    sq_z <= SUM_W'(mag_z) * SUM_W'(mag_z);
  end

  // Stage 3: sum of squares (each at most 2^62, so no overflow).
  side_t            s3_side;
  logic [SUM_W-1:0] sum_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else begin
      s3_side.valid <= s2_side.valid;
    end
    s3_side.idx         <= s2_side.idx;
    s3_side.below_start <= 1'b0;
    s3_side.beyond_end  <= 1'b0;
    sum_sq <= sq_x + sq_y + sq_z;
  end

  // Stage 4: range compare, feed the root chain.
  side_t            sq_side [SQRT_CELLS+1];
  logic [SUM_W-1:0] sq_rad  [SQRT_CELLS+1];
  logic [REM_W-1:0] sq_rem  [SQRT_CELLS+1];
  logic [COORD_W-1:0] sq_root [SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0].valid <= 1'b0;
    end else begin
      sq_side[0].valid <= s3_side.valid;
    end
    sq_side[0].idx         <= s3_side.idx;
    sq_side[0].below_start <= (sum_sq < start_sq);
    sq_side[0].beyond_end  <= (sum_sq >= end_sq);
    sq_rad[0]  <= sum_sq;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    daf_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (sq_side[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_out (sq_side[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // Distance past the start point.
  side_t              nm_side;
  logic [COORD_W-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_side.valid <= 1'b0;
    end else begin
      nm_side.valid <= sq_side[SQRT_CELLS].valid;
    end
    nm_side.idx         <= sq_side[SQRT_CELLS].idx;
    nm_side.below_start <= sq_side[SQRT_CELLS].below_start;
    nm_side.beyond_end  <= sq_side[SQRT_CELLS].beyond_end;
    num <= sq_root[SQRT_CELLS] - fade_start;
  end

  // Scale by the alpha span, then feed the divider chain.
  side_t              dv_side [DIV_CELLS+1];
  logic [COORD_W-1:0] dv_rem  [DIV_CELLS+1];
  logic [ALPHA_W-1:0] dv_low  [DIV_CELLS+1];
  logic [ALPHA_W-1:0] dv_quo  [DIV_CELLS+1];
  logic [PROD_W-1:0]  prod;

  assign prod = PROD_W'(num) * PROD_W'(alpha_span);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_side[0].valid <= 1'b0;
    end else begin
      dv_side[0].valid <= nm_side.valid;
    end
    dv_side[0].idx         <= nm_side.idx;
    dv_side[0].below_start <= nm_side.below_start;
    dv_side[0].beyond_end  <= nm_side.beyond_end;
    // quotient stays below 2^16, so the high part is already below den
    dv_rem[0] <= prod[PROD_W-1:ALPHA_W];
    dv_low[0] <= prod[ALPHA_W-1:0];
    dv_quo[0] <= '0;
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    daf_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .den      (den),
      .side_in  (dv_side[j]),
      .rem_in   (dv_rem[j]),
      .low_in   (dv_low[j]),
      .quo_in   (dv_quo[j]),
      .side_out (dv_side[j+1]),
      .rem_out  (dv_rem[j+1]),
      .low_out  (dv_low[j+1]),
      .quo_out  (dv_quo[j+1])
    );
  end

  // Output register: pick the alpha.
  side_t              fin;
  logic [ALPHA_W-1:0] step;
  logic [ALPHA_W-1:0] alpha_next;

  assign fin  = dv_side[DIV_CELLS];
  assign step = dv_quo[DIV_CELLS];

  always_comb begin
    if (fin.below_start) begin
      alpha_next = start_alpha;
    end else if (fin.beyond_end) begin
      alpha_next = end_alpha;
    end else if (fade_up) begin
      alpha_next = start_alpha + step;
    end else begin
      alpha_next = start_alpha - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    out_index <= fin.idx;
    alpha     <= alpha_next;
  end

`ifndef SYNTHESIS
  a_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result strobe raised straight out of reset");

  a_done_follows_chain: assert property (@(posedge clk) disable iff (rst)
    fin.valid |=> done)
    else $error("transaction lost at the output register");

  a_alpha_in_span: assert property (@(posedge clk) disable iff (rst)
    (fin.valid && !fin.below_start && !fin.beyond_end && (step > alpha_span)) |-> 1'b0)
    else $error("interpolation step exceeds the alpha span");
`endif

endmodule

// ===== dv/distance_alpha_fade_unit_test.sv =====
// Self-checking testbench for the distance alpha fade unit.
module distance_alpha_fade_unit_test;
  import daf_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x, y, z;
  } particle_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [ALPHA_W-1:0] a;
  } fade_t;

  localparam int WATCHDOG = 2000;

  logic clk = 0, rst = 1;
  logic start = 0, cfg_we = 0;
  logic [IDX_W-1:0] particle_index = '0;
  logic signed [COORD_W-1:0] disp_x = '0, disp_y = '0, disp_z = '0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FADE_START;
  logic [COORD_W-1:0] cfg_data = '0;
  logic busy, done;
  logic [IDX_W-1:0] out_index;
  logic [ALPHA_W-1:0] alpha;

  distance_alpha_fade_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor copy of the registers
  logic [31:0] fade_start, fade_end;
  logic [15:0] alpha_near, alpha_far;

  particle_t pending[$];
  fade_t     expected_fades[$];
  int        idle_pct = 0;
  int        errors = 0, checked = 0, quiet = 0;

  function automatic logic [63:0] square_mag(logic signed [31:0] v);
    logic [63:0] m;
    m = v[31] ? 64'(-64'(v)) : 64'(v);
    return m * m;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] faded_alpha(particle_t p);
    logic [63:0] sum, s2, e2, d, stp;
    sum = square_mag(p.x) + square_mag(p.y) + square_mag(p.z);
    s2 = 64'(fade_start) * 64'(fade_start);
    e2 = 64'(fade_end) * 64'(fade_end);
    if (sum < s2) return alpha_near;
    if (sum >= e2) return alpha_far;
    d = root_floor(sum);
    if (alpha_far >= alpha_near) begin
      stp = (64'(alpha_far - alpha_near) * (d - fade_start)) / 64'(fade_end - fade_start);
      return alpha_near + stp[15:0];
    end
    stp = (64'(alpha_near - alpha_far) * (d - fade_start)) / 64'(fade_end - fade_start);
    return alpha_near - stp[15:0];
  endfunction

  // driver; predict each transaction at its accepting edge
  always @(posedge clk) begin
    if (start && !busy && !rst) begin
      particle_t acc;
      acc.idx = particle_index;
      acc.x = disp_x;
      acc.y = disp_y;
      acc.z = disp_z;
      expected_fades.push_back('{particle_index, faded_alpha(acc)});
    end
    if (!rst && (!start || !busy)) begin
      if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        particle_t p;
        p = pending.pop_front();
        start <= 1;
        particle_index <= p.idx;
        disp_x <= p.x;
        disp_y <= p.y;
        disp_z <= p.z;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (done) begin
        if (expected_fades.size() == 0) begin
          $display("%0t: unexpected result idx=%h alpha=%h", $time, out_index, alpha);
          errors++;
        end else begin
          fade_t f;
          f = expected_fades.pop_front();
          checked++;
          if (f.idx !== out_index) begin
            $display("%0t: out_index expected %h actual %h", $time, f.idx, out_index);
            errors++;
          end
          if (f.a !== alpha) begin
            $display("%0t: alpha expected %h actual %h", $time, f.a, alpha);
            errors++;
          end
        end
      end
      if (quiet >= WATCHDOG) begin
        $display("timeout after %0d quiet cycles", quiet);
        $display("distance_alpha_fade_unit_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] random_coord(int span);
    case ($urandom_range(5))
      0: return 32'($urandom);
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom_range(1) ? 32'(int'($urandom_range(span))) :
                                          -32'(int'($urandom_range(span)));
    endcase
  endfunction

  task automatic queue_particle(logic signed [31:0] x, y, z);
    pending.push_back('{16'($urandom), x, y, z});
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !start);
    wait (expected_fades.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (r)
      REG_FADE_START:  fade_start = v;
      REG_FADE_END:    fade_end = v;
      REG_START_ALPHA: alpha_near = v[15:0];
      REG_END_ALPHA:   alpha_far = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_fade(logic [31:0] s, e, logic [15:0] an, af);
    write_reg(REG_FADE_START, s);
    write_reg(REG_FADE_END, e);
    write_reg(REG_START_ALPHA, {16'h0, an});
    write_reg(REG_END_ALPHA, {16'h0, af});
  endtask

  initial begin
    int span;
    fade_start = 0;
    fade_end = 0;
    alpha_near = 16'hffff;
    alpha_far = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    // reset defaults: both distances zero, every particle takes the end alpha
    queue_particle(0, 0, 0);
    queue_particle(32'sh7fffffff, 0, 0);
    drain();
    set_fade(32'h0001_0000, 32'h0010_0000, 16'hffff, 16'h0000);
    queue_particle(0, 0, 0);
    queue_particle(32'sh0001_0000, 0, 0);
    queue_particle(32'sh0000_ffff, 0, 0);
    queue_particle(32'sh0008_0000, 32'sh0008_0000, -32'sh0008_0000);
    queue_particle(32'sh000f_ffff, 0, 0);
    queue_particle(32'sh0010_0000, 0, 0);
    queue_particle(32'sh80000000, 32'sh80000000, 32'sh80000000);
    queue_particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    queue_particle(-1, -1, -1);
    pending.push_back('{16'hffff, 32'sh0004_0000, 0, 0});
    pending.push_back('{16'h0000, 32'sh0004_0000, 0, 0});
    drain();
    // rising alpha, then end not above start
    set_fade(32'h0002_0000, 32'h0003_0000, 16'h0000, 16'hffff);
    queue_particle(32'sh0002_8000, 0, 0);
    queue_particle(32'sh0001_0000, 0, 0);
    drain();
    set_fade(32'h0005_0000, 32'h0005_0000, 16'h1234, 16'habcd);
    queue_particle(32'sh0004_0000, 0, 0);
    queue_particle(32'sh0006_0000, 0, 0);
    drain();
    set_fade(32'hffff_ffff, 32'h0000_0000, 16'h8000, 16'h0001);
    queue_particle(32'sh7fffffff, 0, 0);
    queue_particle(32'sh80000000, 32'sh80000000, 32'sh80000000);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] s, e;
      idle_pct = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 8 : 0;
      if (ph == 7) begin
        s = 0;
        e = 32'hffff_ffff;
      end else begin
        s = $urandom_range(ph + 1) << ($urandom_range(20) + 2);
        e = s + ($urandom_range(255) << $urandom_range(22)) + 1;
      end
      set_fade(s, e, 16'($urandom), 16'($urandom));
      span = (e > 32'h7fff_ffff) ? 32'h7fff_ffff : int'(e);
      for (int i = 0; i < 56; i++)
        queue_particle(random_coord(span / 2), random_coord(span / 2), random_coord(span / 2));
      drain();
    end
    $display("Covered %0d results across reset defaults, equal, zero and reversed distances,",
             checked);
    $display("rising and falling alpha ramps, extreme coordinates and sender idling.");
    if (errors == 0) $display("distance_alpha_fade_unit_test: PASS");
    else $display("distance_alpha_fade_unit_test: FAIL");
    $finish;
  end
endmodule
